FILE: hw/rtl/bmsrfc_pkg.sv
// ----------------------------------------------------------------------------
// bmsrfc_pkg
// Shared constants for the battery-monitor reply frame checker: command,
// format and status codes, protocol bytes, CRC parameters and storage sizes.
// ----------------------------------------------------------------------------
package bmsrfc_pkg;

   // storage sizes
   localparam int PAYLOAD_MAX = 128;
   localparam int CELL_LIMIT  = 32;
   localparam int PAYLOAD_AW  = $clog2(PAYLOAD_MAX);
   localparam int FRAME_LIMIT = 263;
   // cell counter: holds half of an 8-bit length or the cell limit itself
   localparam int CNT_W       = 8;

   // request commands
   localparam logic [1:0] CMD_BEGIN = 2'd0;
   localparam logic [1:0] CMD_BYTE  = 2'd1;
   localparam logic [1:0] CMD_ABORT = 2'd2;

   // frame formats
   localparam logic [1:0] FMT_VAL32 = 2'd0;
   localparam logic [1:0] FMT_VAL16 = 2'd1;
   localparam logic [1:0] FMT_ACK   = 2'd2;
   localparam logic [1:0] FMT_CELLS = 2'd3;

   // result status
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_BAD_HDR = 3'd1;
   localparam logic [2:0] ST_LEN_CAP = 3'd2;
   localparam logic [2:0] ST_CRC_ERR = 3'd3;
   localparam logic [2:0] ST_TIMEOUT = 3'd4;

   // protocol bytes
   localparam logic [7:0] SYNC_BYTE = 8'hAA;
   localparam logic [7:0] ACK_CODE  = 8'h01;
   localparam logic [7:0] ACK_LEN   = 8'h02;

   // crc-16/modbus, reflected
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

endpackage

FILE: hw/rtl/bmsrfc_ram.sv
// ----------------------------------------------------------------------------
// bmsrfc_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module bmsrfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/bms_response_frame_checker.sv
// ----------------------------------------------------------------------------
// bms_response_frame_checker
// Checks one reply frame of a UART battery-monitor protocol byte by byte:
// sync byte, echoed code, length cap and CRC-16/Modbus trailer, then returns
// a status and the decoded value or the 16-bit cell words of the payload.
// ----------------------------------------------------------------------------
// One request beat is taken at a time; req_ready is high only while the block
// is idle. A frame byte that goes into the CRC is taken in S_IDLE and then run
// through the bit-serial CRC-16 unit in S_CRC, one bit per cycle, while no new
// beat is taken. Trailer bytes skip the CRC unit. A result beat is held on the
// rsp_ outputs until taken; each cell word of a length-prefixed reply is read
// from the payload RAM through S_RDLO, S_RDHI and S_LOAD (low byte, high byte,
// load) before it is shown. The payload RAM needs no clearing pass, words are
// read only from bytes written in the same reply.
// ----------------------------------------------------------------------------
module bms_response_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_rx_byte,
   input  logic [7:0]  req_expected_code,
   input  logic [1:0]  req_frame_format,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_value,
   output logic [4:0]  rsp_cell_index,
   output logic [5:0]  rsp_num_cells,
   output logic        rsp_last
);

   localparam int AW = bmsrfc_pkg::PAYLOAD_AW;
   localparam int CW = bmsrfc_pkg::CNT_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CRC,
      S_RDLO,
      S_RDHI,
      S_LOAD,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic          armed_ff, armed_in;
   logic [8:0]    byte_count_ff, byte_count_in;
   logic [15:0]   crc_ff, crc_in;
   logic [2:0]    bit_cnt_ff, bit_cnt_in;
   logic [7:0]    code_ff, code_in;
   logic [1:0]    fmt_ff, fmt_in;
   logic [7:0]    plen_ff, plen_in;
   logic [31:0]   value_shift_ff, value_shift_in;
   logic [7:0]    trailer_low_ff, trailer_low_in;
   logic          header_bad_ff, header_bad_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [7:0]    lo_ff, lo_in;

   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [31:0]   rsp_value_ff, rsp_value_in;
   logic [4:0]    rsp_cell_index_ff, rsp_cell_index_in;
   logic [5:0]    rsp_num_cells_ff, rsp_num_cells_in;
   logic          rsp_last_ff, rsp_last_in;

   // byte decode
   logic [8:0]    pos;
   logic [7:0]    rx;
   logic          fmt_cells;
   logic          known;
   logic [8:0]    total;
   logic          feed;
   logic          at_trl_lo;
   logic          at_end;
   logic          hdr_bad_new;
   logic [31:0]   value_new;
   logic [1:0]    shift_sel;
   logic          len_over;
   logic          store_byte;
   logic [15:0]   got_crc;
   logic [CW-1:0] cells;

   // payload ram
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   always_comb begin
      pos       = byte_count_ff;
      rx        = req_rx_byte;
      fmt_cells = (fmt_ff == bmsrfc_pkg::FMT_CELLS);
      known     = !fmt_cells || (pos >= 9'd3);
      case (fmt_ff)
         bmsrfc_pkg::FMT_VAL32: total = 9'd8;
         bmsrfc_pkg::FMT_VAL16: total = 9'd6;
         bmsrfc_pkg::FMT_ACK:   total = 9'd5;
         default:               total = {1'b0, plen_ff} + 9'd5;
      endcase
      feed      = !known || (pos < total - 9'd2);
      at_trl_lo = known && (pos == total - 9'd2);
      at_end    = known && (pos == total - 9'd1);

      hdr_bad_new = header_bad_ff;
      if (pos == 9'd0 && rx != bmsrfc_pkg::SYNC_BYTE) begin
         hdr_bad_new = 1'b1;
      end
      if (pos == 9'd1 && rx != ((fmt_ff == bmsrfc_pkg::FMT_ACK) ?
                                bmsrfc_pkg::ACK_CODE : code_ff)) begin
         hdr_bad_new = 1'b1;
      end
      if (pos == 9'd2 && fmt_ff == bmsrfc_pkg::FMT_ACK && rx != bmsrfc_pkg::ACK_LEN) begin
         hdr_bad_new = 1'b1;
      end

      // little-endian value bytes start at position two
      shift_sel = 2'(pos - 9'd2);
      value_new = value_shift_ff;
      if ((fmt_ff == bmsrfc_pkg::FMT_VAL32 && pos >= 9'd2 && pos < 9'd6) ||
          (fmt_ff == bmsrfc_pkg::FMT_VAL16 && pos >= 9'd2 && pos < 9'd4)) begin
         value_new = value_shift_ff | ({24'd0, rx} << {shift_sel, 3'b000});
      end

      len_over = ({1'b0, rx} > 9'(bmsrfc_pkg::PAYLOAD_MAX)) ||
                 ({1'b0, rx} + 9'd5 > 9'(bmsrfc_pkg::FRAME_LIMIT));

      store_byte = fmt_cells && (pos >= 9'd3) && (pos < 9'd3 + {1'b0, plen_ff}) &&
                   (pos - 9'd3 < 9'(bmsrfc_pkg::PAYLOAD_MAX));
      wr_addr    = AW'(pos - 9'd3);
      rd_addr    = AW'({idx_ff, (state_ff == S_RDHI)});

      got_crc = {rx, trailer_low_ff};
      cells   = ({1'b0, plen_ff[7:1]} > CW'(bmsrfc_pkg::CELL_LIMIT)) ?
                CW'(bmsrfc_pkg::CELL_LIMIT) : {1'b0, plen_ff[7:1]};
   end

   always_comb begin
      state_in          = state_ff;
      armed_in          = armed_ff;
      byte_count_in     = byte_count_ff;
      crc_in            = crc_ff;
      bit_cnt_in        = bit_cnt_ff;
      code_in           = code_ff;
      fmt_in            = fmt_ff;
      plen_in           = plen_ff;
      value_shift_in    = value_shift_ff;
      trailer_low_in    = trailer_low_ff;
      header_bad_in     = header_bad_ff;
      idx_in            = idx_ff;
      cnt_in            = cnt_ff;
      lo_in             = lo_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_value_in      = rsp_value_ff;
      rsp_cell_index_in = rsp_cell_index_ff;
      rsp_num_cells_in  = rsp_num_cells_ff;
      rsp_last_in       = rsp_last_ff;
      wr_en             = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_cmd)
                  bmsrfc_pkg::CMD_BEGIN: begin
                     code_in        = req_expected_code;
                     fmt_in         = req_frame_format;
                     armed_in       = 1'b1;
                     byte_count_in  = 9'd0;
                     crc_in         = bmsrfc_pkg::CRC_INIT;
                     plen_in        = 8'd0;
                     value_shift_in = 32'd0;
                     trailer_low_in = 8'd0;
                     header_bad_in  = 1'b0;
                  end
                  bmsrfc_pkg::CMD_ABORT: begin
                     if (armed_ff) begin
                        armed_in          = 1'b0;
                        byte_count_in     = 9'd0;
                        rsp_status_in     = bmsrfc_pkg::ST_TIMEOUT;
                        rsp_value_in      = 32'd0;
                        rsp_cell_index_in = 5'd0;
                        rsp_num_cells_in  = 6'd0;
                        rsp_last_in       = 1'b1;
                        state_in          = S_OUT;
                     end
                  end
                  bmsrfc_pkg::CMD_BYTE: begin
                     if (armed_ff) begin
                        header_bad_in  = hdr_bad_new;
                        value_shift_in = value_new;
                        wr_en          = store_byte;
                        byte_count_in  = pos + 9'd1;
                        if (feed) begin
                           crc_in     = crc_ff ^ {8'd0, rx};
                           bit_cnt_in = 3'd0;
                           state_in   = S_CRC;
                        end
                        if (at_trl_lo) begin
                           trailer_low_in = rx;
                        end
                        // error results share these fields
                        rsp_value_in      = 32'd0;
                        rsp_cell_index_in = 5'd0;
                        rsp_num_cells_in  = 6'd0;
                        rsp_last_in       = 1'b1;
                        if (fmt_cells && pos == 9'd2) begin
                           plen_in = rx;
                           if (hdr_bad_new || len_over) begin
                              armed_in      = 1'b0;
                              byte_count_in = 9'd0;
                              rsp_status_in = hdr_bad_new ? bmsrfc_pkg::ST_BAD_HDR :
                                                            bmsrfc_pkg::ST_LEN_CAP;
                              state_in      = S_OUT;
                           end
                        end else if (at_end) begin
                           armed_in      = 1'b0;
                           byte_count_in = 9'd0;
                           rsp_status_in = bmsrfc_pkg::ST_OK;
                           state_in      = S_OUT;
                           if (got_crc != crc_ff) begin
                              rsp_status_in = bmsrfc_pkg::ST_CRC_ERR;
                           end else if (!fmt_cells && hdr_bad_new) begin
                              rsp_status_in = bmsrfc_pkg::ST_BAD_HDR;
                           end else if (fmt_ff == bmsrfc_pkg::FMT_VAL32 ||
                                        fmt_ff == bmsrfc_pkg::FMT_VAL16) begin
                              rsp_value_in = value_new;
                           end else if (fmt_cells && cells != '0) begin
                              cnt_in   = cells;
                              idx_in   = '0;
                              state_in = S_RDLO;
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // shared crc unit, one bit per cycle
         S_CRC: begin
            crc_in     = crc_ff[0] ? ((crc_ff >> 1) ^ bmsrfc_pkg::CRC_POLY) : (crc_ff >> 1);
            bit_cnt_in = bit_cnt_ff + 3'd1;
            if (bit_cnt_ff == 3'd7) begin
               state_in = S_IDLE;
            end
         end
         S_RDLO: begin
            state_in = S_RDHI;
         end
         S_RDHI: begin
            lo_in    = rd_data;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            rsp_status_in     = bmsrfc_pkg::ST_OK;
            rsp_value_in      = {16'd0, rd_data, lo_ff};
            rsp_cell_index_in = idx_ff[4:0];
            rsp_num_cells_in  = cnt_ff[5:0];
            rsp_last_in       = (idx_ff + CW'(1) == cnt_ff);
            state_in          = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               if (rsp_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_RDLO;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         armed_ff       <= 1'b0;
         byte_count_ff  <= 9'd0;
         crc_ff         <= bmsrfc_pkg::CRC_INIT;
         bit_cnt_ff     <= 3'd0;
         code_ff        <= 8'd0;
         fmt_ff         <= 2'd0;
         plen_ff        <= 8'd0;
         value_shift_ff <= 32'd0;
         trailer_low_ff <= 8'd0;
         header_bad_ff  <= 1'b0;
         idx_ff         <= '0;
         cnt_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         armed_ff       <= armed_in;
         byte_count_ff  <= byte_count_in;
         crc_ff         <= crc_in;
         bit_cnt_ff     <= bit_cnt_in;
         code_ff        <= code_in;
         fmt_ff         <= fmt_in;
         plen_ff        <= plen_in;
         value_shift_ff <= value_shift_in;
         trailer_low_ff <= trailer_low_in;
         header_bad_ff  <= header_bad_in;
         idx_ff         <= idx_in;
         cnt_ff         <= cnt_in;
      end
      lo_ff             <= lo_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_value_ff      <= rsp_value_in;
      rsp_cell_index_ff <= rsp_cell_index_in;
      rsp_num_cells_ff  <= rsp_num_cells_in;
      rsp_last_ff       <= rsp_last_in;
   end

   bmsrfc_ram #(
      .WIDTH(8),
      .DEPTH(bmsrfc_pkg::PAYLOAD_MAX)
   ) u_payload_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(rx),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = (state_ff == S_OUT);
   assign rsp_status     = rsp_status_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_cell_index = rsp_cell_index_ff;
   assign rsp_num_cells  = rsp_num_cells_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

FILE: dv/bms_response_frame_checker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bms_response_frame_checker_test
// Self-checking bench for the reply frame checker. Request beats carry whole
// and truncated reply frames with good and corrupted trailers and headers,
// over-cap lengths, timeouts, restarts and ignored beats. A built-in model of
// the checker predicts every result beat, checked field by field when taken.
// ----------------------------------------------------------------------------
module bms_response_frame_checker_test;

   localparam int CLK_PERIOD    = 4;
   localparam int DRAIN_LIMIT   = 50000;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_GAP       = 20;
   // the fourth command encoding has no meaning and must be dropped
   localparam logic [1:0] CMD_NONE = 2'd3;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] value;
      logic [4:0]  cell_index;
      logic [5:0]  num_cells;
      logic        last;
   } frame_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_cmd;
   logic [7:0]  req_rx_byte;
   logic [7:0]  req_expected_code;
   logic [1:0]  req_frame_format;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_value;
   logic [4:0]  rsp_cell_index;
   logic [5:0]  rsp_num_cells;
   logic        rsp_last;

   // model of the checker state
   logic        frame_armed   = 1'b0;
   int          frame_pos     = 0;
   logic [15:0] frame_crc     = bmsrfc_pkg::CRC_INIT;
   logic [7:0]  frame_code    = '0;
   logic [1:0]  frame_fmt     = bmsrfc_pkg::FMT_VAL32;
   int          frame_plen    = 0;
   logic [31:0] frame_value   = '0;
   logic [7:0]  frame_crc_lo  = '0;
   logic        frame_hdr_bad = 1'b0;
   logic [7:0]  frame_store [0:bmsrfc_pkg::PAYLOAD_MAX-1];

   frame_result_type pending_results[$];
   logic [7:0]       reply_bytes[$];

   int req_idle_pct;
   int rsp_idle_pct;
   int rsp_stall_cycles = 0;
   int mismatch_count   = 0;
   int beats_sent       = 0;
   int beats_used       = 0;
   int replies_started  = 0;
   int results_checked  = 0;
   int status_seen [0:4] = '{default: 0};

   bms_response_frame_checker DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_rx_byte       (req_rx_byte),
      .req_expected_code (req_expected_code),
      .req_frame_format  (req_frame_format),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_value         (rsp_value),
      .rsp_cell_index    (rsp_cell_index),
      .rsp_num_cells     (rsp_num_cells),
      .rsp_last          (rsp_last)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   initial begin
      #4ms;
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ bmsrfc_pkg::CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   function automatic void push_result(logic [2:0] st, logic [31:0] val, logic [4:0] idx,
                                       logic [5:0] cnt, logic lst);
      frame_result_type r;
      r.status     = st;
      r.value      = val;
      r.cell_index = idx;
      r.num_cells  = cnt;
      r.last       = lst;
      pending_results.push_back(r);
   endfunction

   // advances the model by one request beat; returns 0 when the beat is dropped
   function automatic bit reply_predict(logic [1:0] cmd, logic [7:0] b, logic [7:0] code,
                                        logic [1:0] fmt);
      int          pos;
      int          total;
      int          cnt;
      bit          known;
      logic [7:0]  want;
      logic [15:0] got;
      if (cmd == bmsrfc_pkg::CMD_BEGIN) begin
         frame_code    = code;
         frame_fmt     = fmt;
         frame_armed   = 1'b1;
         frame_pos     = 0;
         frame_crc     = bmsrfc_pkg::CRC_INIT;
         frame_plen    = 0;
         frame_value   = '0;
         frame_crc_lo  = '0;
         frame_hdr_bad = 1'b0;
         replies_started++;
         return 1'b1;
      end
      if (cmd == bmsrfc_pkg::CMD_ABORT) begin
         if (!frame_armed) return 1'b0;
         frame_armed = 1'b0;
         frame_pos   = 0;
         push_result(bmsrfc_pkg::ST_TIMEOUT, '0, '0, '0, 1'b1);
         return 1'b1;
      end
      if (cmd != bmsrfc_pkg::CMD_BYTE || !frame_armed) return 1'b0;

      pos = frame_pos;
      case (frame_fmt)
         bmsrfc_pkg::FMT_VAL32: begin
            total = 8;
            known = 1'b1;
         end
         bmsrfc_pkg::FMT_VAL16: begin
            total = 6;
            known = 1'b1;
         end
         bmsrfc_pkg::FMT_ACK: begin
            total = 5;
            known = 1'b1;
         end
         default: begin
            total = frame_plen + 5;
            known = (pos >= 3);
         end
      endcase

      // the two trailer bytes stay out of the running crc
      if (!known || pos < total - 2) frame_crc = crc16_step(frame_crc, b);

      want = (frame_fmt == bmsrfc_pkg::FMT_ACK) ? bmsrfc_pkg::ACK_CODE : frame_code;
      if ((pos == 0 && b != bmsrfc_pkg::SYNC_BYTE) || (pos == 1 && b != want) ||
          (pos == 2 && frame_fmt == bmsrfc_pkg::FMT_ACK && b != bmsrfc_pkg::ACK_LEN)) begin
         frame_hdr_bad = 1'b1;
      end

      if ((frame_fmt == bmsrfc_pkg::FMT_VAL32 && pos >= 2 && pos < 6) ||
          (frame_fmt == bmsrfc_pkg::FMT_VAL16 && pos >= 2 && pos < 4)) begin
         frame_value = frame_value | (32'(b) << (8 * (pos - 2)));
      end

      if (frame_fmt == bmsrfc_pkg::FMT_CELLS) begin
         if (pos == 2) begin
            frame_plen = int'(b);
            if (frame_hdr_bad) begin
               frame_armed = 1'b0;
               frame_pos   = 0;
               push_result(bmsrfc_pkg::ST_BAD_HDR, '0, '0, '0, 1'b1);
               return 1'b1;
            end
            if (frame_plen > bmsrfc_pkg::PAYLOAD_MAX ||
                frame_plen + 5 > bmsrfc_pkg::FRAME_LIMIT) begin
               frame_armed = 1'b0;
               frame_pos   = 0;
               push_result(bmsrfc_pkg::ST_LEN_CAP, '0, '0, '0, 1'b1);
               return 1'b1;
            end
            frame_pos = 3;
            return 1'b1;
         end
         if (pos >= 3 && pos < 3 + frame_plen && pos - 3 < bmsrfc_pkg::PAYLOAD_MAX) begin
            frame_store[pos - 3] = b;
         end
      end

      if (known && pos == total - 2) frame_crc_lo = b;
      if (known && pos == total - 1) begin
         got         = {b, frame_crc_lo};
         frame_armed = 1'b0;
         frame_pos   = 0;
         if (got != frame_crc) begin
            push_result(bmsrfc_pkg::ST_CRC_ERR, '0, '0, '0, 1'b1);
         end else if (frame_fmt != bmsrfc_pkg::FMT_CELLS && frame_hdr_bad) begin
            push_result(bmsrfc_pkg::ST_BAD_HDR, '0, '0, '0, 1'b1);
         end else if (frame_fmt == bmsrfc_pkg::FMT_VAL32 ||
                      frame_fmt == bmsrfc_pkg::FMT_VAL16) begin
            push_result(bmsrfc_pkg::ST_OK, frame_value, '0, '0, 1'b1);
         end else if (frame_fmt == bmsrfc_pkg::FMT_ACK) begin
            push_result(bmsrfc_pkg::ST_OK, '0, '0, '0, 1'b1);
         end else begin
            cnt = frame_plen / 2;
            if (cnt > bmsrfc_pkg::CELL_LIMIT) cnt = bmsrfc_pkg::CELL_LIMIT;
            if (cnt == 0) begin
               push_result(bmsrfc_pkg::ST_OK, '0, '0, '0, 1'b1);
            end
            for (int i = 0; i < cnt; i++) begin
               push_result(bmsrfc_pkg::ST_OK,
                           {16'h0000, frame_store[2 * i + 1], frame_store[2 * i]},
                           5'(i), 6'(cnt), (i + 1 == cnt));
            end
         end
         return 1'b1;
      end

      frame_pos = (pos + 1) % 512;
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------
   task automatic send_beat(input logic [1:0] cmd, input logic [7:0] rx,
                            input logic [7:0] code, input logic [1:0] fmt);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct && gap < MAX_GAP) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_cmd           <= cmd;
      req_rx_byte       <= rx;
      req_expected_code <= code;
      req_frame_format  <= fmt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
      if (reply_predict(cmd, rx, code, fmt)) beats_used++;
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // frame body without the crc trailer
   function automatic void build_body(logic [1:0] fmt, logic [7:0] code, int len);
      reply_bytes.delete();
      reply_bytes.push_back(bmsrfc_pkg::SYNC_BYTE);
      case (fmt)
         bmsrfc_pkg::FMT_VAL32: begin
            reply_bytes.push_back(code);
            repeat (4) reply_bytes.push_back(pick_byte());
         end
         bmsrfc_pkg::FMT_VAL16: begin
            reply_bytes.push_back(code);
            repeat (2) reply_bytes.push_back(pick_byte());
         end
         bmsrfc_pkg::FMT_ACK: begin
            reply_bytes.push_back(bmsrfc_pkg::ACK_CODE);
            reply_bytes.push_back(bmsrfc_pkg::ACK_LEN);
         end
         default: begin
            reply_bytes.push_back(code);
            reply_bytes.push_back(8'(len));
            repeat (len) reply_bytes.push_back(pick_byte());
         end
      endcase
   endfunction

   function automatic void append_crc();
      logic [15:0] c;
      c = bmsrfc_pkg::CRC_INIT;
      foreach (reply_bytes[i]) c = crc16_step(c, reply_bytes[i]);
      reply_bytes.push_back(c[7:0]);
      reply_bytes.push_back(c[15:8]);
   endfunction

   task automatic send_reply(input logic [7:0] code, input logic [1:0] fmt, input int cut);
      send_beat(bmsrfc_pkg::CMD_BEGIN, 8'($urandom), code, fmt);
      for (int i = 0; i < cut; i++) begin
         send_beat(bmsrfc_pkg::CMD_BYTE, reply_bytes[i], 8'($urandom), 2'($urandom));
      end
   endtask

   task automatic wait_drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (pending_results.size() != 0) begin
         $error("%0d expected result beats never arrived", pending_results.size());
         mismatch_count++;
         pending_results.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------
   initial begin : rsp_drive
      int n;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (rsp_stall_cycles > 0) begin
            n = rsp_stall_cycles;
            rsp_stall_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (rsp_status <= bmsrfc_pkg::ST_TIMEOUT) status_seen[rsp_status]++;
         if (pending_results.size() == 0) begin
            $error("result beat with nothing expected: status %0d value %0h",
                   rsp_status, rsp_value);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_value !== want.value) begin
               $error("value: expected %0h, got %0h", want.value, rsp_value);
               mismatch_count++;
            end
            if (rsp_cell_index !== want.cell_index) begin
               $error("cell_index: expected %0d, got %0d", want.cell_index, rsp_cell_index);
               mismatch_count++;
            end
            if (rsp_num_cells !== want.num_cells) begin
               $error("num_cells: expected %0d, got %0d", want.num_cells, rsp_num_cells);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_ignored_beats();
      send_beat(CMD_NONE, 8'hFF, 8'hFF, bmsrfc_pkg::FMT_CELLS);
      send_beat(bmsrfc_pkg::CMD_BYTE, bmsrfc_pkg::SYNC_BYTE, 8'h00, bmsrfc_pkg::FMT_VAL32);
      send_beat(bmsrfc_pkg::CMD_ABORT, 8'h00, 8'h00, bmsrfc_pkg::FMT_VAL32);
   endtask

   task automatic test_timeout_and_restart();
      send_beat(bmsrfc_pkg::CMD_BEGIN, 8'h00, 8'h3C, bmsrfc_pkg::FMT_VAL32);
      send_beat(bmsrfc_pkg::CMD_ABORT, 8'h00, 8'h00, bmsrfc_pkg::FMT_VAL32);
      // a begin on an armed checker drops the reply in flight
      send_beat(bmsrfc_pkg::CMD_BEGIN, 8'h00, 8'h11, bmsrfc_pkg::FMT_CELLS);
      send_beat(bmsrfc_pkg::CMD_BYTE, bmsrfc_pkg::SYNC_BYTE, 8'h00, bmsrfc_pkg::FMT_VAL32);
      build_body(bmsrfc_pkg::FMT_ACK, 8'h00, 0);
      append_crc();
      send_reply(8'hC3, bmsrfc_pkg::FMT_ACK, reply_bytes.size());
   endtask

   task automatic test_cell_edges();
      build_body(bmsrfc_pkg::FMT_CELLS, 8'h00, 0);
      append_crc();
      send_reply(8'h00, bmsrfc_pkg::FMT_CELLS, reply_bytes.size());
      // one cell plus a dangling odd byte
      build_body(bmsrfc_pkg::FMT_CELLS, 8'h7E, 3);
      append_crc();
      send_reply(8'h7E, bmsrfc_pkg::FMT_CELLS, reply_bytes.size());
   endtask

   task automatic test_length_cap();
      build_body(bmsrfc_pkg::FMT_CELLS, 8'hFF, 255);
      send_reply(8'hFF, bmsrfc_pkg::FMT_CELLS, 3);
   endtask

   task automatic test_check_order();
      // bad sync and bad trailer together: the crc error wins
      build_body(bmsrfc_pkg::FMT_VAL16, 8'h5A, 0);
      reply_bytes[0] = ~bmsrfc_pkg::SYNC_BYTE;
      append_crc();
      reply_bytes[reply_bytes.size() - 1] = reply_bytes[reply_bytes.size() - 1] ^ 8'h80;
      send_reply(8'h5A, bmsrfc_pkg::FMT_VAL16, reply_bytes.size());
   endtask

   task automatic test_random_replies(input int n_items);
      int          stop_at;
      int          pick;
      int          len;
      int          k;
      int          cut;
      logic [1:0]  fmt;
      logic [7:0]  code;
      stop_at = beats_used + n_items;
      while (beats_used < stop_at) begin
         pick = $urandom_range(99);
         fmt  = 2'($urandom);
         code = pick_byte();
         len  = ($urandom_range(19) == 0) ? $urandom_range(bmsrfc_pkg::PAYLOAD_MAX) :
                                            $urandom_range(24);
         if (pick >= 89 && pick < 93) begin
            fmt = bmsrfc_pkg::FMT_CELLS;
            len = $urandom_range(255, bmsrfc_pkg::PAYLOAD_MAX + 1);
         end
         build_body(fmt, code, len);
         if (pick >= 70 && pick < 78) begin
            // damage to one of the first three bytes with a trailer that still matches
            k = $urandom_range(2);
            reply_bytes[k] = reply_bytes[k] ^ 8'(1 << $urandom_range(7));
         end
         append_crc();
         if (pick >= 60 && pick < 70) begin
            k = $urandom_range(reply_bytes.size() - 1);
            reply_bytes[k] = reply_bytes[k] ^ 8'(1 << $urandom_range(7));
         end
         cut = reply_bytes.size();
         if (pick >= 78 && pick < 89) cut = $urandom_range(reply_bytes.size() - 1);
         if (pick >= 89 && pick < 93) cut = 3 + $urandom_range(2);

         if (pick >= 93) begin
            repeat ($urandom_range(3, 1)) begin
               case ($urandom_range(2))
                  0: send_beat(bmsrfc_pkg::CMD_BYTE, 8'($urandom), 8'($urandom),
                               2'($urandom));
                  1: send_beat(bmsrfc_pkg::CMD_ABORT, 8'($urandom), 8'($urandom),
                               2'($urandom));
                  default: send_beat(CMD_NONE, 8'($urandom), 8'($urandom), 2'($urandom));
               endcase
            end
         end else begin
            send_reply(code, fmt, cut);
            // truncated replies either time out or get dropped by the next begin
            if (pick >= 78 && pick < 84) send_beat(bmsrfc_pkg::CMD_ABORT, 8'($urandom),
                                                   8'($urandom), 2'($urandom));
         end
      end
   endtask

   task automatic test_output_stall();
      logic [7:0] code;
      logic [1:0] fmt;
      rsp_stall_cycles = 400;
      for (int i = 0; i < 6; i++) begin
         code = 8'($urandom);
         fmt  = (i % 2 == 0) ? bmsrfc_pkg::FMT_CELLS : bmsrfc_pkg::FMT_VAL32;
         build_body(fmt, code, 16);
         append_crc();
         send_reply(code, fmt, reply_bytes.size());
      end
      wait_drain();
   endtask

   task automatic test_longest_payload();
      build_body(bmsrfc_pkg::FMT_CELLS, 8'hA5, bmsrfc_pkg::PAYLOAD_MAX);
      append_crc();
      send_reply(8'hA5, bmsrfc_pkg::FMT_CELLS, reply_bytes.size());
      build_body(bmsrfc_pkg::FMT_CELLS, 8'h5A, 2 * bmsrfc_pkg::CELL_LIMIT + 1);
      append_crc();
      send_reply(8'h5A, bmsrfc_pkg::FMT_CELLS, reply_bytes.size());
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_cmd           = bmsrfc_pkg::CMD_BEGIN;
      req_rx_byte       = '0;
      req_expected_code = '0;
      req_frame_format  = bmsrfc_pkg::FMT_VAL32;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 24;
      rsp_idle_pct = 70;
      test_ignored_beats();
      test_timeout_and_restart();
      test_cell_edges();
      test_length_cap();
      test_check_order();
      wait_drain();
      test_random_replies(30);
      wait_drain();
      test_output_stall();

      req_idle_pct = 70;
      rsp_idle_pct = 24;
      test_random_replies(30);
      test_longest_payload();
      wait_drain();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_replies(30);
      wait_drain();

      $display("sent %0d request beats (%0d acted on, %0d replies begun), checked %0d results",
               beats_sent, beats_used, replies_started, results_checked);
      $display("status mix: ok %0d, bad header %0d, over cap %0d, crc error %0d, timeout %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
